// ----- rtl/boxavg_pkg.sv -----
package boxavg_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_FACTOR   = 16;
	localparam int HEIGHT_LIMIT = 2048;

	localparam int CHAN_W     = 8;
	localparam int FACTOR_W   = 5;
	localparam int DIM_W      = 12;
	localparam int POS_W      = 11;
	localparam int IDX_W      = $clog2(MAX_WIDTH);
	localparam int SUB_W      = $clog2(MAX_FACTOR);
	localparam int HSUM_W     = 12;
	localparam int SUM_W      = 16;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W    = 25;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_FACTOR = 2'd0,
		REG_IN_WIDTH     = 2'd1,
		REG_IN_HEIGHT    = 2'd2
	} cfg_reg_t;

	// one accepted input that falls inside a full block
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [IDX_W-1:0]  idx;
		logic              col_first;
		logic              col_last;
		logic              row_first;
		logic              blk_last;
		logic              frame_end;
	} job_t;

	typedef struct packed {
		logic at_origin;
	} front_status_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} queue_status_t;

	// ceil(2^24 / (k+1)^2); exact truncating divide for any 16-bit sum
	function automatic logic [RECIP_W-1:0] recip_of(input logic [SUB_W-1:0] k);
		logic [RECIP_W-1:0] r;
		case (k)
			4'd0:    r = 25'd16777216;
			4'd1:    r = 25'd4194304;
			4'd2:    r = 25'd1864136;
			4'd3:    r = 25'd1048576;
			4'd4:    r = 25'd671089;
			4'd5:    r = 25'd466034;
			4'd6:    r = 25'd342393;
			4'd7:    r = 25'd262144;
			4'd8:    r = 25'd207127;
			4'd9:    r = 25'd167773;
			4'd10:   r = 25'd138655;
			4'd11:   r = 25'd116509;
			4'd12:   r = 25'd99274;
			4'd13:   r = 25'd85599;
			4'd14:   r = 25'd74566;
			default: r = 25'd65536;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/boxavg_if.sv -----
interface rgb_in_if;
	logic                            valid;
	logic                            ready;
	logic [boxavg_pkg::CHAN_W-1:0]   red_in;
	logic [boxavg_pkg::CHAN_W-1:0]   green_in;
	logic [boxavg_pkg::CHAN_W-1:0]   blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rgb_out_if;
	logic                            valid;
	logic                            ready;
	logic [boxavg_pkg::CHAN_W-1:0]   red_out;
	logic [boxavg_pkg::CHAN_W-1:0]   green_out;
	logic [boxavg_pkg::CHAN_W-1:0]   blue_out;
	logic                            frame_end;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output frame_end, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input frame_end, output ready);
endinterface

interface cfg_wr_if;
	logic                              valid;
	logic                              ready;
	logic [boxavg_pkg::CFG_IDX_W-1:0]  index;
	logic [boxavg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/boxavg_front.sv -----
module boxavg_front (
	input  logic                                clk,
	input  logic                                arst_n,
	rgb_in_if.sink                              din,
	cfg_wr_if.sink                              cfg,
	input  logic                                q_full,
	output logic                                push,
	output boxavg_pkg::job_t                    push_job,
	output logic [boxavg_pkg::FACTOR_W-1:0]     factor,
	output boxavg_pkg::front_status_t           status
);

	logic [boxavg_pkg::FACTOR_W-1:0] factor_q;
	logic [boxavg_pkg::DIM_W-1:0]    width_q;
	logic [boxavg_pkg::DIM_W-1:0]    height_q;

	logic [boxavg_pkg::POS_W-1:0]    col_q;
	logic [boxavg_pkg::POS_W-1:0]    row_q;
	logic [boxavg_pkg::SUB_W-1:0]    cx_q;
	logic [boxavg_pkg::SUB_W-1:0]    ry_q;
	logic [boxavg_pkg::IDX_W-1:0]    idx_q;
	logic [boxavg_pkg::POS_W-1:0]    bcol_q;
	logic [boxavg_pkg::POS_W-1:0]    brow_q;

	logic [boxavg_pkg::FACTOR_W-1:0] f_eff;
	logic [boxavg_pkg::DIM_W-1:0]    w_eff;
	logic [boxavg_pkg::DIM_W-1:0]    h_eff;
	logic [boxavg_pkg::SUB_W-1:0]    f_m1;
	logic [boxavg_pkg::DIM_W:0]      bcol_end;
	logic [boxavg_pkg::DIM_W:0]      brow_end;
	logic [boxavg_pkg::DIM_W:0]      bcol_next_end;
	logic [boxavg_pkg::DIM_W:0]      brow_next_end;
	logic                            col_act;
	logic                            row_act;
	logic                            col_lastblk;
	logic                            row_lastblk;
	logic                            cx_last;
	logic                            ry_last;
	logic                            col_wrap;
	logic                            row_wrap;
	logic                            accept;
	logic                            cfg_hit;

	always_comb begin
		if (factor_q == '0)
			f_eff = 5'd1;
		else if (factor_q > 5'(boxavg_pkg::MAX_FACTOR))
			f_eff = 5'(boxavg_pkg::MAX_FACTOR);
		else
			f_eff = factor_q;

		if (width_q == '0)
			w_eff = 12'd1;
		else if (width_q > 12'(boxavg_pkg::MAX_WIDTH))
			w_eff = 12'(boxavg_pkg::MAX_WIDTH);
		else
			w_eff = width_q;

		if (height_q == '0)
			h_eff = 12'd1;
		else if (height_q > 12'(boxavg_pkg::HEIGHT_LIMIT))
			h_eff = 12'(boxavg_pkg::HEIGHT_LIMIT);
		else
			h_eff = height_q;
	end

	assign f_m1 = 4'(f_eff - 5'd1);

	// a block is inside the output image when it ends on or before the edge
	assign bcol_end      = {2'b00, bcol_q} + {8'd0, f_eff};
	assign brow_end      = {2'b00, brow_q} + {8'd0, f_eff};
	assign bcol_next_end = bcol_end + {8'd0, f_eff};
	assign brow_next_end = brow_end + {8'd0, f_eff};
	assign col_act       = bcol_end <= {1'b0, w_eff};
	assign row_act       = brow_end <= {1'b0, h_eff};
	assign col_lastblk   = bcol_next_end > {1'b0, w_eff};
	assign row_lastblk   = brow_next_end > {1'b0, h_eff};

	assign cx_last  = cx_q == f_m1;
	assign ry_last  = ry_q == f_m1;
	assign col_wrap = ({1'b0, col_q} + 12'd1) >= w_eff;
	assign row_wrap = ({1'b0, row_q} + 12'd1) >= h_eff;

	assign din.ready = !q_full;
	assign cfg.ready = 1'b1;
	assign accept    = din.valid && din.ready;
	assign cfg_hit   = cfg.valid && cfg.ready;

	assign push = accept && col_act && row_act;

	always_comb begin
		push_job.red       = din.red_in;
		push_job.green     = din.green_in;
		push_job.blue      = din.blue_in;
		push_job.idx       = idx_q;
		push_job.col_first = cx_q == '0;
		push_job.col_last  = cx_last;
		push_job.row_first = ry_q == '0;
		push_job.blk_last  = cx_last && ry_last;
		push_job.frame_end = cx_last && ry_last && col_lastblk && row_lastblk;
	end

	assign factor = f_eff;
	assign status.at_origin = (col_q == '0) && (row_q == '0) && (cx_q == '0) &&
		(ry_q == '0) && (idx_q == '0) && (bcol_q == '0) && (brow_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= 5'd1;
			width_q  <= 12'(boxavg_pkg::MAX_WIDTH);
			height_q <= 12'(boxavg_pkg::HEIGHT_LIMIT);
			col_q    <= '0;
			row_q    <= '0;
			cx_q     <= '0;
			ry_q     <= '0;
			idx_q    <= '0;
			bcol_q   <= '0;
			brow_q   <= '0;
		end else if (cfg_hit) begin
			unique case (boxavg_pkg::cfg_reg_t'(cfg.index))
				boxavg_pkg::REG_SCALE_FACTOR: factor_q <= cfg.data[boxavg_pkg::FACTOR_W-1:0];
				boxavg_pkg::REG_IN_WIDTH:     width_q  <= cfg.data;
				boxavg_pkg::REG_IN_HEIGHT:    height_q <= cfg.data;
				default: ;
			endcase
			if (cfg.index == boxavg_pkg::REG_SCALE_FACTOR ||
				cfg.index == boxavg_pkg::REG_IN_WIDTH ||
				cfg.index == boxavg_pkg::REG_IN_HEIGHT) begin
				col_q  <= '0;
				row_q  <= '0;
				cx_q   <= '0;
				ry_q   <= '0;
				idx_q  <= '0;
				bcol_q <= '0;
				brow_q <= '0;
			end
		end else if (accept) begin
			if (col_wrap) begin
				col_q  <= '0;
				cx_q   <= '0;
				idx_q  <= '0;
				bcol_q <= '0;
				if (row_wrap) begin
					row_q  <= '0;
					ry_q   <= '0;
					brow_q <= '0;
				end else begin
					row_q <= row_q + 11'd1;
					if (ry_last) begin
						ry_q   <= '0;
						brow_q <= 11'(brow_end);
					end else begin
						ry_q <= ry_q + 4'd1;
					end
				end
			end else begin
				col_q <= col_q + 11'd1;
				if (cx_last) begin
					cx_q   <= '0;
					idx_q  <= idx_q + 11'd1;
					bcol_q <= 11'(bcol_end);
				end else begin
					cx_q <= cx_q + 4'd1;
				end
			end
		end
	end

endmodule

// ----- rtl/boxavg_queue.sv -----
module boxavg_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  boxavg_pkg::job_t            push_job,
	input  logic                        pop,
	output boxavg_pkg::job_t            head,
	output boxavg_pkg::queue_status_t   status
);

	boxavg_pkg::job_t                  slot_q [boxavg_pkg::QUEUE_DEPTH];
	logic [boxavg_pkg::QPTR_W-1:0]     wr_q;
	logic [boxavg_pkg::QPTR_W-1:0]     rd_q;
	logic [boxavg_pkg::QCNT_W-1:0]     count_q;
	logic                              do_push;
	logic                              do_pop;

	assign status.count = count_q;
	assign status.full  = count_q == boxavg_pkg::QCNT_W'(boxavg_pkg::QUEUE_DEPTH);
	assign status.empty = count_q == '0;
	assign head         = slot_q[rd_q];

	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/boxavg_back.sv -----
module boxavg_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  boxavg_pkg::job_t                  head,
	input  logic                              head_valid,
	input  logic [boxavg_pkg::FACTOR_W-1:0]   factor,
	output logic                              pop,
	rgb_out_if.source                         dout
);

	localparam int SUMS_W = 3 * boxavg_pkg::SUM_W;
	localparam int PROD_W = boxavg_pkg::SUM_W + boxavg_pkg::RECIP_W;
	localparam int Q_LO   = boxavg_pkg::RECIP_SHIFT;
	localparam int Q_HI   = boxavg_pkg::RECIP_SHIFT + boxavg_pkg::CHAN_W - 1;

	// one entry per output column: {red, green, blue} partial block sums
	logic [SUMS_W-1:0] sums_mem [boxavg_pkg::MAX_WIDTH];
	logic [SUMS_W-1:0] rd_q;

	logic [boxavg_pkg::HSUM_W-1:0] hsum_r_q, hsum_g_q, hsum_b_q;
	logic [boxavg_pkg::HSUM_W-1:0] hsum_r, hsum_g, hsum_b;
	logic [boxavg_pkg::SUM_W-1:0]  tot_r, tot_g, tot_b;
	logic [boxavg_pkg::SUM_W-1:0]  prev_r, prev_g, prev_b;

	logic                          valid_s1;
	logic [boxavg_pkg::SUM_W-1:0]  tot_r_s1, tot_g_s1, tot_b_s1;
	logic                          fe_s1;

	logic                          valid_s2;
	logic [boxavg_pkg::CHAN_W-1:0] avg_r_s2, avg_g_s2, avg_b_s2;
	logic                          fe_s2;

	logic [boxavg_pkg::RECIP_W-1:0] recip;
	logic [PROD_W-1:0]             prod_r, prod_g, prod_b;
	logic                          s2_free;
	logic                          s1_free;
	logic                          adv_s1;

	assign s2_free = !valid_s2 || dout.ready;
	assign adv_s1  = valid_s1 && s2_free;
	assign s1_free = !valid_s1 || s2_free;
	assign pop     = head_valid && (!head.blk_last || s1_free);

	// horizontal run within one block row, then fold in the rows above
	assign hsum_r = head.col_first ? 12'(head.red)   : hsum_r_q + 12'(head.red);
	assign hsum_g = head.col_first ? 12'(head.green) : hsum_g_q + 12'(head.green);
	assign hsum_b = head.col_first ? 12'(head.blue)  : hsum_b_q + 12'(head.blue);

	assign prev_r = head.row_first ? '0 : rd_q[3*boxavg_pkg::SUM_W-1:2*boxavg_pkg::SUM_W];
	assign prev_g = head.row_first ? '0 : rd_q[2*boxavg_pkg::SUM_W-1:boxavg_pkg::SUM_W];
	assign prev_b = head.row_first ? '0 : rd_q[boxavg_pkg::SUM_W-1:0];

	assign tot_r = prev_r + 16'(hsum_r);
	assign tot_g = prev_g + 16'(hsum_g);
	assign tot_b = prev_b + 16'(hsum_b);

	always_ff @(posedge clk) begin
		if (pop && head.col_first && !head.row_first)
			rd_q <= sums_mem[head.idx];
		if (pop && head.col_last)
			sums_mem[head.idx] <= {tot_r, tot_g, tot_b};
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hsum_r_q <= hsum_r;
			hsum_g_q <= hsum_g;
			hsum_b_q <= hsum_b;
		end
		if (pop && head.blk_last) begin
			tot_r_s1 <= tot_r;
			tot_g_s1 <= tot_g;
			tot_b_s1 <= tot_b;
			fe_s1    <= head.frame_end;
		end
		if (adv_s1) begin
			avg_r_s2 <= prod_r[Q_HI:Q_LO];
			avg_g_s2 <= prod_g[Q_HI:Q_LO];
			avg_b_s2 <= prod_b[Q_HI:Q_LO];
			fe_s2    <= fe_s1;
		end
	end

	// divide by factor squared: multiply by a rounded-up reciprocal
	assign recip  = boxavg_pkg::recip_of(4'(factor - 5'd1));
	assign prod_r = PROD_W'(tot_r_s1) * PROD_W'(recip);
	assign prod_g = PROD_W'(tot_g_s1) * PROD_W'(recip);
	assign prod_b = PROD_W'(tot_b_s1) * PROD_W'(recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pop && head.blk_last)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (dout.ready)
				valid_s2 <= 1'b0;
		end
	end

	assign dout.valid     = valid_s2;
	assign dout.red_out   = avg_r_s2;
	assign dout.green_out = avg_g_s2;
	assign dout.blue_out  = avg_b_s2;
	assign dout.frame_end = fe_s2;

endmodule

// ----- rtl/box_average_downscaler.sv -----
// A block's last beat passes through the queue, then the s1 sum and s2 average registers.
// Throughput: one input beat per cycle; the front stalls only when the four-entry queue is full,
// which happens only while the output is held off. The accumulator memory sees at most one read
// and one write per block row, so the back keeps pace at any factor.
// Reset: position counters cleared, registers at factor 1 and 2048 x 2048, queue and output empty;
// the accumulator memory is not cleared, each entry is written by its block's first row.
module box_average_downscaler (
	input  logic       clk,
	input  logic       arst_n,
	rgb_in_if.sink     din,
	rgb_out_if.source  dout,
	cfg_wr_if.sink     cfg
);

	boxavg_pkg::job_t                    push_job;
	boxavg_pkg::job_t                    head;
	boxavg_pkg::front_status_t           front_stat;
	boxavg_pkg::queue_status_t           q_stat;
	logic                                push;
	logic                                pop;
	logic [boxavg_pkg::FACTOR_W-1:0]     factor;

	boxavg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.cfg      (cfg),
		.q_full   (q_stat.full),
		.push     (push),
		.push_job (push_job),
		.factor   (factor),
		.status   (front_stat)
	);

	boxavg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_stat)
	);

	boxavg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_stat.empty),
		.factor     (factor),
		.pop        (pop),
		.dout       (dout)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= boxavg_pkg::QCNT_W'(boxavg_pkg::QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.ready && (cfg.index == boxavg_pkg::REG_SCALE_FACTOR ||
		cfg.index == boxavg_pkg::REG_IN_WIDTH || cfg.index == boxavg_pkg::REG_IN_HEIGHT))
		|=> front_stat.at_origin)
		else $error("register write did not restart the image");

endmodule
